[hw/rtl/bsoc_pkg.sv]
// Shared types and constants for the battery state-of-charge estimator.
`timescale 1ns / 1ps
`default_nettype none

package bsoc_pkg;

  localparam int SAMPLE_W = 11;
  localparam int CURVE_MV_W = 13;
  localparam int PCT_W = 7;
  localparam int PREV_W = 8;
  localparam int CURVE_POINTS = 21;
  localparam int IDX_W = 5;
  localparam int QUOT_W = 7;
  localparam int QSTEP_W = 3;
  localparam int NUM_W = CURVE_MV_W + PCT_W;
  localparam int OUT_MV_W = 13;

  localparam logic [PREV_W-1:0] PCT_NONE = 8'd255;
  localparam logic [PREV_W-1:0] PCT_LIMIT = 8'd100;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
  localparam logic [PCT_W-1:0] MAX_DROP_RESET = 7'd10;
  localparam logic [OUT_MV_W-1:0] MV_FIELD_MAX = 13'd8191;
  localparam logic [IDX_W-1:0] LAST_IDX = 5'd20;

  // LiPo discharge curve, from full charge down to empty.
  localparam logic [CURVE_MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
    13'd3910, 13'd3870, 13'd3850, 13'd3840, 13'd3820, 13'd3800, 13'd3790,
    13'd3770, 13'd3750, 13'd3730, 13'd3710, 13'd3690, 13'd3610, 13'd3270
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65, 7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_LIMIT
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/battery_soc_curve_estimator.sv]
// Top level: median, scaling, curve lookup with interpolation and fall limiting.
`timescale 1ns / 1ps
`default_nettype none

// Takes three divider-side millivolt samples per transfer and returns the battery
// voltage (median times DIVIDER_RATIO, saturated at 8191) and a state of charge
// from a 21-point LiPo curve, with drops limited to max_drop per estimate. One
// item is in work at a time. The median and scaling are registered with the input
// transfer, then the end-of-curve checks run; inside the curve there follow a walk
// through the synchronous curve ROM, one curve entry per cycle (up to 20), the
// ST_MUL setup state, seven steps of the restoring divider and the limiter state.
// The limiter state repeats while the output register still holds an earlier
// result that has not been taken.
// The input is accepted again as soon as the block is idle, even while the last
// result still waits in the output register.
module battery_soc_curve_estimator #(
  parameter int DIVIDER_RATIO = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [10:0] sample_first, [21:11] sample_second, [32:22] sample_third
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [12:0] battery_millivolts, [19:13] charge_percent
  output logic [23:0]      m_tdata
);

  localparam int PROD_W = bsoc_pkg::SAMPLE_W + $clog2(DIVIDER_RATIO);
  localparam int MV_W = (PROD_W > bsoc_pkg::CURVE_MV_W) ? PROD_W : bsoc_pkg::CURVE_MV_W;

  bsoc_pkg::state_t state, state_next;

  logic [bsoc_pkg::IDX_W-1:0]      idx, idx_next;
  logic [bsoc_pkg::CURVE_MV_W-1:0] rom_mv;
  logic [bsoc_pkg::PCT_W-1:0]      rom_pct;
  logic [bsoc_pkg::CURVE_MV_W-1:0] hi_mv;
  logic [bsoc_pkg::PCT_W-1:0]      hi_pct;
  logic [bsoc_pkg::PCT_W-1:0]      lo_pct;
  logic [bsoc_pkg::CURVE_MV_W-1:0] span;
  logic [bsoc_pkg::NUM_W-1:0]      rem;
  logic [bsoc_pkg::QUOT_W-1:0]     quot;
  logic [bsoc_pkg::QSTEP_W-1:0]    qstep;
  logic [MV_W-1:0]                 mv;
  logic [bsoc_pkg::PREV_W-1:0]     pct;
  logic [bsoc_pkg::PREV_W-1:0]     prev_pct;
  logic [bsoc_pkg::PCT_W-1:0]      max_drop;
  logic [bsoc_pkg::OUT_MV_W-1:0]   out_mv;
  logic [bsoc_pkg::PCT_W-1:0]      out_pct;

  logic [bsoc_pkg::SAMPLE_W-1:0] sa, sb, sc, med;
  logic                          in_xfer;
  logic                          out_free;
  logic                          seg_hit;
  logic [bsoc_pkg::CURVE_MV_W-1:0] diff;
  logic [bsoc_pkg::NUM_W-1:0]    span_sh;
  logic [bsoc_pkg::PREV_W-1:0]   pct_lim;

  assign sa = s_tdata[10:0];
  assign sb = s_tdata[21:11];
  assign sc = s_tdata[32:22];

  always_comb begin
    if ((sa <= sb && sb <= sc) || (sc <= sb && sb <= sa)) begin
      med = sb;
    end else if ((sb <= sa && sa <= sc) || (sc <= sa && sa <= sb)) begin
      med = sa;
    end else begin
      med = sc;
    end
  end

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign seg_hit  = mv >= MV_W'(rom_mv);
  assign diff     = bsoc_pkg::CURVE_MV_W'(mv - MV_W'(rom_mv));
  assign span_sh  = bsoc_pkg::NUM_W'(span) << qstep;

  // Fall limiter; an out-of-range previous value means there is no estimate yet.
  always_comb begin
    pct_lim = pct;
    if (prev_pct <= bsoc_pkg::PCT_LIMIT && pct < prev_pct &&
        (prev_pct - pct) > bsoc_pkg::PREV_W'(max_drop)) begin
      pct_lim = prev_pct - bsoc_pkg::PREV_W'(max_drop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsoc_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    s_tready   = 1'b0;
    case (state)
      bsoc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = bsoc_pkg::ST_CHECK;
        end
      end
      bsoc_pkg::ST_CHECK: begin
        if (mv >= MV_W'(bsoc_pkg::CURVE_MV[0]) ||
            mv <= MV_W'(bsoc_pkg::CURVE_MV[bsoc_pkg::CURVE_POINTS-1])) begin
          state_next = bsoc_pkg::ST_LIMIT;
        end else begin
          idx_next   = bsoc_pkg::IDX_W'(1);
          state_next = bsoc_pkg::ST_WALK;
        end
      end
      bsoc_pkg::ST_WALK: begin
        if (seg_hit) begin
          state_next = bsoc_pkg::ST_MUL;
        end else if (idx == bsoc_pkg::LAST_IDX) begin
          state_next = bsoc_pkg::ST_LIMIT;
        end else begin
          idx_next = idx + bsoc_pkg::IDX_W'(1);
        end
      end
      bsoc_pkg::ST_MUL: begin
        if (span == '0 || hi_pct < lo_pct) begin
          state_next = bsoc_pkg::ST_LIMIT;
        end else begin
          state_next = bsoc_pkg::ST_DIV;
        end
      end
      bsoc_pkg::ST_DIV: begin
        if (qstep == '0) begin
          state_next = bsoc_pkg::ST_LIMIT;
        end
      end
      bsoc_pkg::ST_LIMIT: begin
        if (out_free) begin
          state_next = bsoc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsoc_pkg::ST_IDLE;
      end
    endcase
  end

  // Curve ROM with a registered read port; it always holds the entry at idx.
  always_ff @(posedge clk) begin
    rom_mv  <= bsoc_pkg::CURVE_MV[idx_next];
    rom_pct <= bsoc_pkg::CURVE_PCT[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_drop <= bsoc_pkg::MAX_DROP_RESET;
    end else if (cfg_wr_en) begin
      max_drop <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pct <= bsoc_pkg::PCT_NONE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == bsoc_pkg::ST_LIMIT && out_free) begin
        m_tvalid <= 1'b1;
        prev_pct <= pct_lim;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bsoc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          mv <= MV_W'(MV_W'(med) * MV_W'(DIVIDER_RATIO));
        end
      end
      bsoc_pkg::ST_CHECK: begin
        hi_mv  <= bsoc_pkg::CURVE_MV[0];
        hi_pct <= bsoc_pkg::CURVE_PCT[0];
        if (mv >= MV_W'(bsoc_pkg::CURVE_MV[0])) begin
          pct <= bsoc_pkg::PREV_W'(bsoc_pkg::PCT_FULL);
        end else begin
          pct <= bsoc_pkg::PREV_W'(bsoc_pkg::PCT_EMPTY);
        end
      end
      bsoc_pkg::ST_WALK: begin
        if (seg_hit) begin
          lo_pct <= rom_pct;
          span   <= hi_mv - rom_mv;
          rem    <= bsoc_pkg::NUM_W'(diff) *
                    bsoc_pkg::NUM_W'(hi_pct - rom_pct);
        end else begin
          hi_mv  <= rom_mv;
          hi_pct <= rom_pct;
          pct    <= bsoc_pkg::PREV_W'(bsoc_pkg::PCT_EMPTY);
        end
      end
      bsoc_pkg::ST_MUL: begin
        pct   <= bsoc_pkg::PREV_W'(lo_pct);
        quot  <= '0;
        qstep <= bsoc_pkg::QSTEP_W'(bsoc_pkg::QUOT_W - 1);
      end
      bsoc_pkg::ST_DIV: begin
        // One quotient bit per cycle, most significant first.
        if (rem >= span_sh) begin
          rem         <= rem - span_sh;
          quot[qstep] <= 1'b1;
        end
        qstep <= qstep - bsoc_pkg::QSTEP_W'(1);
        if (qstep == '0) begin
          pct <= bsoc_pkg::PREV_W'(lo_pct) + bsoc_pkg::PREV_W'(quot) +
                 bsoc_pkg::PREV_W'(rem >= span_sh);
        end
      end
      bsoc_pkg::ST_LIMIT: begin
        if (out_free) begin
          if (mv > MV_W'(bsoc_pkg::MV_FIELD_MAX)) begin
            out_mv <= bsoc_pkg::MV_FIELD_MAX;
          end else begin
            out_mv <= bsoc_pkg::OUT_MV_W'(mv);
          end
          out_pct <= pct_lim[bsoc_pkg::PCT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {4'b0000, out_pct, out_mv};

endmodule

`default_nettype wire
